// ===== rtl/mawt_pkg.sv =====
// ----------------------------------------------------------------------------
// mawt_pkg
// Shared types and constants for the moving average with trend unit.
// ----------------------------------------------------------------------------
package mawt_pkg;

  // window_length register width and its value after reset
  localparam int          CFG_W         = 7;
  localparam logic [6:0]  CFG_LEN_RESET = 7'd16;

  // status of the sequential divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== rtl/moving_average_with_trend_unit.sv =====
// After an item is accepted the block runs its sum, divide and done states and
// registers the result when the done state finishes; no new item is taken until
// then. The bit-serial divider runs SUMW = SAMPLE_BITS + log2(MAX_WINDOW) steps.
// Both windows sit in single-port-write memories whose reads are registered on accept.
// Reset and every window_length write clear counts, pointers, sum and trend;
// reset sets window_length to 16. Memory contents are never cleared.
// ----------------------------------------------------------------------------
// moving_average_with_trend_unit
// Sliding-window moving average of Q16.16 samples plus the trend between the
// newest and oldest kept averages.
// ----------------------------------------------------------------------------
module moving_average_with_trend_unit #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_mean_value,
  output logic signed [SAMPLE_BITS:0]   out_trend_value,
  input  logic                          cfg_we,
  input  logic [mawt_pkg::CFG_W-1:0]    cfg_window_length
);

  localparam int CNTW = $clog2(MAX_WINDOW + 1);
  localparam int PW   = $clog2(MAX_WINDOW);
  localparam int SUMW = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int TW   = SAMPLE_BITS + 1;
  localparam int LCW  = (CNTW > mawt_pkg::CFG_W) ? CNTW : mawt_pkg::CFG_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // index wrap for values below twice the window length
  function automatic logic [PW-1:0] wrap_idx(input logic [CNTW:0] v,
                                             input logic [CNTW-1:0] n);
    logic [CNTW:0] t;
    begin
      t = (v >= {1'b0, n}) ? (v - {1'b0, n}) : v;
      return t[PW-1:0];
    end
  endfunction

  // window memories
  logic signed [SAMPLE_BITS-1:0] smem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] mmem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] srd_r;
  logic signed [SAMPLE_BITS-1:0] mrd_r;

  // control and state registers
  logic [1:0]                    state_r, state_nxt;
  logic [mawt_pkg::CFG_W-1:0]    wl_r, wl_nxt;
  logic [CNTW-1:0]               sc_r, sc_nxt;
  logic [PW-1:0]                 so_r, so_nxt;
  logic signed [SUMW-1:0]        sum_r, sum_nxt;
  logic [CNTW-1:0]               mc_r, mc_nxt;
  logic [PW-1:0]                 mo_r, mo_nxt;
  logic signed [TW-1:0]          trend_r, trend_nxt;
  logic                          ov_r, ov_nxt;

  // per-item registers
  logic signed [SAMPLE_BITS-1:0] smp_r;
  logic [PW-1:0]                 s_wa_r;
  logic                          sfull_r;
  logic [PW-1:0]                 m_wa_r;
  logic                          mfull_r;
  logic                          mfwd_r;
  logic signed [SAMPLE_BITS-1:0] omean_r;
  logic signed [TW-1:0]          otrend_r;

  // combinational terms
  logic [LCW-1:0]                wl_ext;
  logic [CNTW-1:0]               len;
  logic                          accept;
  logic                          s_full;
  logic                          m_full;
  logic [PW-1:0]                 s_wa;
  logic [PW-1:0]                 m_wa;
  logic [PW-1:0]                 m_ra;
  logic signed [SUMW-1:0]        dropped;
  logic signed [SUMW-1:0]        sum_new;
  logic [CNTW-1:0]               sc_new;
  logic                          finish;
  logic                          push;
  logic signed [SAMPLE_BITS-1:0] mean_w;
  logic signed [SAMPLE_BITS-1:0] old_mean;
  logic signed [TW-1:0]          trend_new;
  logic signed [SUMW-1:0]        div_q;
  mawt_pkg::div_sts_t            div_sts;

  // effective window length: zero acts as one, clamp at the maximum
  assign wl_ext = LCW'(wl_r);
  always_comb begin
    if (wl_r == '0) begin
      len = CNTW'(1);
    end else if (wl_ext > LCW'(MAX_WINDOW)) begin
      len = CNTW'(MAX_WINDOW);
    end else begin
      len = CNTW'(wl_ext);
    end
  end

  // addresses decided when the item is taken
  assign accept = in_valid && !in_stall;
  assign s_full = (sc_r >= len);
  assign m_full = (mc_r >= len);
  assign s_wa   = s_full ? so_r : wrap_idx((CNTW+1)'(so_r) + (CNTW+1)'(sc_r), len);
  assign m_wa   = m_full ? mo_r : wrap_idx((CNTW+1)'(mo_r) + (CNTW+1)'(mc_r), len);
  assign m_ra   = m_full ? wrap_idx((CNTW+1)'(mo_r) + (CNTW+1)'(1), len) : mo_r;

  // running sum update once the dropped sample is read
  assign dropped = sfull_r ? SUMW'(srd_r) : '0;
  assign sum_new = sum_r + SUMW'(smp_r) - dropped;
  assign sc_new  = sfull_r ? len : (sc_r + CNTW'(1));

  // mean and trend at the end of the division
  assign mean_w    = div_q[SAMPLE_BITS-1:0];
  assign push      = (sc_r > (len >> 1));
  assign old_mean  = mfwd_r ? mean_w : mrd_r;
  assign trend_new = TW'(mean_w) - TW'(old_mean);
  assign finish    = (state_r == ST_DONE) && (!ov_r || !out_stall);

  // sequential divider for sum / count
  mawt_div #(
    .DW (SUMW),
    .VW (CNTW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_SUM),
    .dividend (sum_new),
    .divisor  (sc_new),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    wl_nxt    = wl_r;
    sc_nxt    = sc_r;
    so_nxt    = so_r;
    sum_nxt   = sum_r;
    mc_nxt    = mc_r;
    mo_nxt    = mo_r;
    trend_nxt = trend_r;
    ov_nxt    = ov_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_nxt   = sum_new;
        sc_nxt    = sc_new;
        so_nxt    = sfull_r ? wrap_idx((CNTW+1)'(so_r) + (CNTW+1)'(1), len) : so_r;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (finish) begin
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
          if (push) begin
            mc_nxt    = mfull_r ? len : (mc_r + CNTW'(1));
            mo_nxt    = mfull_r ? wrap_idx((CNTW+1)'(mo_r) + (CNTW+1)'(1), len) : mo_r;
            trend_nxt = trend_new;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // register write clears both windows
    if (cfg_we) begin
      wl_nxt    = cfg_window_length;
      sc_nxt    = '0;
      so_nxt    = '0;
      sum_nxt   = '0;
      mc_nxt    = '0;
      mo_nxt    = '0;
      trend_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wl_r    <= mawt_pkg::CFG_LEN_RESET;
      sc_r    <= '0;
      so_r    <= '0;
      sum_r   <= '0;
      mc_r    <= '0;
      mo_r    <= '0;
      trend_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wl_r    <= wl_nxt;
      sc_r    <= sc_nxt;
      so_r    <= so_nxt;
      sum_r   <= sum_nxt;
      mc_r    <= mc_nxt;
      mo_r    <= mo_nxt;
      trend_r <= trend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // item capture and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r   <= in_sample;
      s_wa_r  <= s_wa;
      sfull_r <= s_full;
      m_wa_r  <= m_wa;
      mfull_r <= m_full;
      mfwd_r  <= (m_ra == m_wa);
    end
    if (finish) begin
      omean_r  <= mean_w;
      otrend_r <= trend_nxt;
    end
  end

  // sample window memory: read oldest on accept, write in sum step
  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) begin
      smem[s_wa_r] <= smp_r;
    end
    if (accept) begin
      srd_r <= smem[so_r];
    end
  end

  // mean window memory: read oldest (next oldest once full) on accept, write at finish
  always_ff @(posedge clk) begin
    if (finish && push) begin
      mmem[m_wa_r] <= mean_w;
    end
    if (accept) begin
      mrd_r <= mmem[m_ra];
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = ov_r;
  assign out_mean_value  = omean_r;
  assign out_trend_value = otrend_r;

endmodule

// ===== rtl/mawt_div.sv =====
// ----------------------------------------------------------------------------
// mawt_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module mawt_div #(
  parameter int DW = 38,
  parameter int VW = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [DW-1:0]  dividend,
  input  logic        [VW-1:0]  divisor,
  output mawt_pkg::div_sts_t    sts,
  output logic signed [DW-1:0]  quotient
);

  localparam int RW = VW + 1;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] mag_r;
  logic [RW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [DW-1:0] dv_u;
  logic [DW-1:0] mag_in;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] rem_sub;
  logic          q_bit;

  // magnitude of the dividend
  assign dv_u   = dividend;
  assign mag_in = dv_u[DW-1] ? (~dv_u + DW'(1)) : dv_u;

  // one restoring step
  assign rem_sh  = {rem_r[RW-2:0], mag_r[DW-1]};
  assign q_bit   = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend register shifts out and takes in quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= mag_in;
      neg_r <= dv_u[DW-1];
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      mag_r <= {mag_r[DW-2:0], q_bit};
      rem_r <= q_bit ? rem_sub : rem_sh;
    end
  end

  assign quotient = neg_r ? (~mag_r + DW'(1)) : mag_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ===== rtl/mawt_chk.sv =====
// ----------------------------------------------------------------------------
// mawt_chk
// Port-level checks for the moving average with trend unit.
// ----------------------------------------------------------------------------
module mawt_chk #(
  parameter int SAMPLE_BITS = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_mean_value,
  input logic [SAMPLE_BITS:0]   out_trend_value
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_mean_value) && $stable(out_trend_value)))
    else $error("stalled result changed");

  // one item at a time: busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item taken while busy");

  // the division comes first, so no new result right after an item
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result too early");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind moving_average_with_trend_unit mawt_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mawt_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_mean_value  (out_mean_value),
  .out_trend_value (out_trend_value)
);

// ===== tb/tb_moving_average_with_trend_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_moving_average_with_trend_unit
// Self-checking bench for the moving average with trend unit. A directed table
// covers sample extremes, mean truncation and window lengths 0, 1, 2, 65 and 127. A
// run of random phases follows, each after its own window length write. Every item
// is predicted in the bench and checked against the block's result stream.
// Both handshakes see random idle cycles, except in random phases 1 and 2.
// ----------------------------------------------------------------------------
module tb_moving_average_with_trend_unit;

  localparam int SMP_W       = 32;
  localparam int WIN_MAX     = 64;
  localparam int CLK_HALF    = 6;
  localparam int RST_CYCLES  = 7;
  localparam int ITEM_TARGET = 1050;
  localparam int IDLE_PCT    = 25;
  localparam int TAIL_CYCLES = 60;
  localparam int TIMEOUT_NS  = 10_000_000;
  localparam int DIR_ROWS    = 24;

  localparam logic [SMP_W-1:0] SMP_MAX = 32'h7FFF_FFFF;
  localparam logic [SMP_W-1:0] SMP_MIN = 32'h8000_0000;

  typedef enum logic {ROW_SAMPLE, ROW_LEN} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [SMP_W-1:0]   value;
    bit                 typed;
    logic signed [SMP_W-1:0] mean;
    logic signed [SMP_W:0]   trend;
  } dir_row_t;

  typedef struct {
    logic signed [SMP_W-1:0] mean;
    logic signed [SMP_W:0]   trend;
  } avg_trend_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [SMP_W-1:0] in_sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SMP_W-1:0] out_mean_value;
  logic signed [SMP_W:0]   out_trend_value;
  logic                    cfg_we = 1'b0;
  logic [mawt_pkg::CFG_W-1:0] cfg_window_length = '0;

  bit         idle_on = 1'b1;
  int         mismatch_cnt = 0;
  avg_trend_t pending_avg_q [$];

  // shadow of the averaging state
  logic [mawt_pkg::CFG_W-1:0] len_reg;
  logic signed [SMP_W-1:0] smp_hist [WIN_MAX];
  int unsigned             smp_cnt;
  int unsigned             smp_head;
  longint                  run_sum;
  logic signed [SMP_W-1:0] avg_hist [WIN_MAX];
  int unsigned             avg_cnt;
  int unsigned             avg_head;
  logic signed [SMP_W:0]   held_slope;

  // directed items: lengths, extremes, truncation toward zero
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_SAMPLE, SMP_MAX,      1'b1, SMP_MAX, 33'sd0},
    '{ROW_SAMPLE, SMP_MIN,      1'b1, 32'sd0,  33'sd0},
    '{ROW_SAMPLE, 32'h0000_0001, 1'b0, 32'sd0, 33'sd0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 32'sd0, 33'sd0},
    '{ROW_SAMPLE, 32'h0001_0000, 1'b0, 32'sd0, 33'sd0},
    '{ROW_SAMPLE, 32'hFFFF_0000, 1'b0, 32'sd0, 33'sd0},
    '{ROW_LEN,    32'd0,        1'b0, 32'sd0,  33'sd0},
    '{ROW_SAMPLE, SMP_MIN,      1'b1, SMP_MIN, 33'sd0},
    '{ROW_SAMPLE, SMP_MAX,      1'b1, SMP_MAX, 33'sd0},
    '{ROW_LEN,    32'd2,        1'b0, 32'sd0,  33'sd0},
    '{ROW_SAMPLE, SMP_MAX,      1'b0, 32'sd0,  33'sd0},
    '{ROW_SAMPLE, SMP_MAX,      1'b0, 32'sd0,  33'sd0},
    '{ROW_SAMPLE, SMP_MIN,      1'b0, 32'sd0,  33'sd0},
    '{ROW_SAMPLE, SMP_MIN,      1'b0, 32'sd0,  33'sd0},
    '{ROW_SAMPLE, SMP_MAX,      1'b0, 32'sd0,  33'sd0},
    '{ROW_SAMPLE, SMP_MAX,      1'b0, 32'sd0,  33'sd0},
    '{ROW_LEN,    32'd127,      1'b0, 32'sd0,  33'sd0},
    '{ROW_SAMPLE, 32'h5555_5555, 1'b0, 32'sd0, 33'sd0},
    '{ROW_SAMPLE, 32'hAAAA_AAAA, 1'b0, 32'sd0, 33'sd0},
    '{ROW_LEN,    32'd65,       1'b0, 32'sd0,  33'sd0},
    '{ROW_SAMPLE, 32'd0,        1'b1, 32'sd0,  33'sd0},
    '{ROW_LEN,    32'd1,        1'b0, 32'sd0,  33'sd0},
    '{ROW_SAMPLE, 32'h1234_5678, 1'b1, 32'sh1234_5678, 33'sd0},
    '{ROW_SAMPLE, 32'd0,        1'b1, 32'sd0,  33'sd0}
  };

  // window lengths of the first random phases
  logic [mawt_pkg::CFG_W-1:0] len_plan [9] = '{7'd64, 7'd1, 7'd127, 7'd2, 7'd0, 7'd3,
                                              7'd65, 7'd16, 7'd31};

  logic [SMP_W-1:0] corner_vals [5] = '{SMP_MAX, SMP_MIN, 32'd0, 32'd1, 32'hFFFF_FFFF};

  always #(CLK_HALF) clk = ~clk;

  moving_average_with_trend_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mean_value    (out_mean_value),
    .out_trend_value   (out_trend_value),
    .cfg_we            (cfg_we),
    .cfg_window_length (cfg_window_length)
  );

  // zero and oversized lengths are clamped
  function automatic int unsigned eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > WIN_MAX) return WIN_MAX;
    return 32'(len_reg);
  endfunction

  function automatic void clear_history();
    smp_cnt    = 0;
    smp_head   = 0;
    run_sum    = 0;
    avg_cnt    = 0;
    avg_head   = 0;
    held_slope = '0;
  endfunction

  // next mean and trend for one accepted sample
  function automatic avg_trend_t calc_avg_trend(input logic signed [SMP_W-1:0] s);
    int unsigned len;
    longint      avg;
    avg_trend_t  r;
    len = eff_len();
    run_sum += longint'(s);
    if (smp_cnt >= len) begin
      run_sum -= longint'(smp_hist[smp_head]);
      smp_hist[smp_head] = s;
      smp_head = (smp_head + 1) % len;
    end else begin
      smp_hist[(smp_head + smp_cnt) % len] = s;
      smp_cnt++;
    end
    // signed division truncates toward zero
    avg = run_sum / longint'(smp_cnt);
    // trend updates only once the sample window is over half full
    if (smp_cnt > len / 2) begin
      if (avg_cnt >= len) begin
        avg_hist[avg_head] = SMP_W'(avg);
        avg_head = (avg_head + 1) % len;
      end else begin
        avg_hist[(avg_head + avg_cnt) % len] = SMP_W'(avg);
        avg_cnt++;
      end
      held_slope = (SMP_W+1)'(avg - longint'(avg_hist[avg_head]));
    end
    r.mean  = SMP_W'(avg);
    r.trend = held_slope;
    return r;
  endfunction

  // offer one item, wait for it to be taken, then log its expectation
  task automatic send_sample(input logic [SMP_W-1:0] s, input bit typed,
                             input logic signed [SMP_W-1:0] mean,
                             input logic signed [SMP_W:0] trend);
    avg_trend_t e;
    if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 100)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    e = calc_avg_trend(s);
    if (typed) begin
      e.mean  = mean;
      e.trend = trend;
    end
    pending_avg_q.push_back(e);
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_avg_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // window length writes only while the block is idle
  task automatic write_length(input logic [mawt_pkg::CFG_W-1:0] v);
    drain_results();
    cfg_we            <= 1'b1;
    cfg_window_length <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    len_reg = v;
    clear_history();
  endtask

  // result side: random stall and field checks
  always @(posedge clk) begin
    avg_trend_t want;
    out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_avg_q.size() == 0) begin
        $display("%0t: unexpected item, mean %0d trend %0d", $time, out_mean_value,
                 out_trend_value);
        mismatch_cnt++;
      end else begin
        want = pending_avg_q.pop_front();
        if (out_mean_value !== want.mean) begin
          $display("%0t: mean expected %0d actual %0d", $time, want.mean, out_mean_value);
          mismatch_cnt++;
        end
        if (out_trend_value !== want.trend) begin
          $display("%0t: trend expected %0d actual %0d", $time, want.trend,
                   out_trend_value);
          mismatch_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int               sent;
    int unsigned      phase;
    int unsigned      n_items;
    logic [mawt_pkg::CFG_W-1:0] plen;
    logic [SMP_W-1:0] s;
    logic [SMP_W-1:0] last_s;
    len_reg = mawt_pkg::CFG_LEN_RESET;
    clear_history();
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LEN) begin
        write_length(dir_rows[i].value[mawt_pkg::CFG_W-1:0]);
      end else begin
        send_sample(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].mean,
                    dir_rows[i].trend);
      end
    end

    // random phases, each at its own window length
    sent   = 0;
    phase  = 0;
    last_s = '0;
    while (sent < ITEM_TARGET) begin
      plen = (phase < $size(len_plan)) ? len_plan[phase] :
             mawt_pkg::CFG_W'($urandom_range(0, 127));
      write_length(plen);
      // phases 1 and 2 run a long stretch with no idling on either side
      idle_on = !(phase == 1 || phase == 2);
      n_items = eff_len() * 3 + $urandom_range(8, 24);
      for (int k = 0; k < n_items && sent < ITEM_TARGET; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: s = $urandom();
          4, 5: begin
            s = $urandom();
            s = {{(SMP_W-20){s[19]}}, s[19:0]};
          end
          6: s = corner_vals[$urandom_range(0, 4)];
          default: s = last_s + SMP_W'($urandom_range(0, 131072)) - SMP_W'(65536);
        endcase
        send_sample(s, 1'b0, '0, '0);
        last_s = s;
        sent++;
        if ($urandom_range(0, 199) == 0) drain_results();
      end
      phase++;
    end
    idle_on = 1'b1;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("tb_moving_average_with_trend_unit: PASS");
    else
      $display("tb_moving_average_with_trend_unit: FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("tb_moving_average_with_trend_unit: FAIL");
    $finish;
  end

endmodule
